### rtl/m3inv_pkg.sv
// Package: element widths, shared types and fixed-point helpers for the 3x3 inverse.
package m3inv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int THR_WIDTH  = 31;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int MAG_WIDTH  = ELEM_WIDTH;
    // dividend 2^(2*FRAC_BITS)
    localparam int DIVD_WIDTH = 2 * FRAC_BITS + 1;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic [THR_WIDTH-1:0] thr_t;
    typedef elem_t [8:0] mat_t;

    // word passed from front to back through the queue
    typedef struct packed {
        mat_t  adj;
        elem_t det;
        logic  sing;
    } front_word_t;

    typedef struct packed {
        mat_t  inv;
        elem_t det;
        logic  sing;
    } result_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // floor shift by FRAC_BITS of a wide signed value, saturate to element range
    function automatic elem_t scale_sat(input logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] s;
        logic signed [SUM_WIDTH-1:0] hi_lim;
        logic signed [SUM_WIDTH-1:0] lo_lim;
        begin
            s      = v >>> FRAC_BITS;
            hi_lim = SUM_WIDTH'(ELEM_MAX);
            lo_lim = SUM_WIDTH'(ELEM_MIN);
            if (s > hi_lim)
                scale_sat = ELEM_MAX;
            else if (s < lo_lim)
                scale_sat = ELEM_MIN;
            else
                scale_sat = s[ELEM_WIDTH-1:0];
        end
    endfunction

endpackage

### rtl/m3inv_front.sv
// Front: cofactors, determinant and singular test, three register stages.
module m3inv_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  m3inv_pkg::mat_t        in_mat,
    input  m3inv_pkg::thr_t        thr,
    input  logic                   stall,
    output logic                   out_valid,
    output m3inv_pkg::front_word_t out_word
);
    import m3inv_pkg::*;

    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;

    // stage 1: products for cofactors
    mat_t  a1_reg;
    prod_t p_reg [9][2];
    prod_t p_next [9][2];
    logic  v1_reg;
    // stage 2: saturated cofactors
    mat_t  a2_reg;
    mat_t  adj2_reg;
    mat_t  adj2_next;
    logic  v2_reg;
    // stage 3: determinant products
    mat_t  adj3_reg;
    prod_t d_reg [3];
    prod_t d_next [3];
    logic  v3_reg;

    sum_t  det_sum;
    elem_t det_val;
    logic [MAG_WIDTH:0] det_mag;

    // index pairs for cofactor c = p*q - r*s
    localparam int CI [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            p_next[i][0] = prod_t'(in_mat[CI[i][0]]) * prod_t'(in_mat[CI[i][1]]);
            p_next[i][1] = prod_t'(in_mat[CI[i][2]]) * prod_t'(in_mat[CI[i][3]]);
        end
        for (int i = 0; i < 9; i++)
            adj2_next[i] = scale_sat(sum_t'(p_reg[i][0]) - sum_t'(p_reg[i][1]));
        d_next[0] = prod_t'(a2_reg[0]) * prod_t'(adj2_reg[0]);
        d_next[1] = prod_t'(a2_reg[1]) * prod_t'(adj2_reg[3]);
        d_next[2] = prod_t'(a2_reg[2]) * prod_t'(adj2_reg[6]);
        det_sum = sum_t'(d_reg[0]) + sum_t'(d_reg[1]) + sum_t'(d_reg[2]);
        det_val = scale_sat(det_sum);
        det_mag = det_val[ELEM_WIDTH-1] ? (MAG_WIDTH+1)'(-(MAG_WIDTH+1)'(signed'(det_val)))
                                        : (MAG_WIDTH+1)'(det_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (!stall)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a1_reg   <= in_mat;
            p_reg    <= p_next;
            a2_reg   <= a1_reg;
            adj2_reg <= adj2_next;
            adj3_reg <= adj2_reg;
            d_reg    <= d_next;
        end
    end

    assign out_valid     = v3_reg;
    assign out_word.adj  = adj3_reg;
    assign out_word.det  = det_val;
    assign out_word.sing = (det_mag <= (MAG_WIDTH+1)'(thr));
endmodule

### rtl/m3inv_queue.sv
// Small FIFO between front and back.
module m3inv_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  m3inv_pkg::front_word_t wr_data,
    input  logic                   rd_en,
    output m3inv_pkg::front_word_t rd_data,
    output logic                   empty,
    output logic [m3inv_pkg::Q_AW:0] count
);
    import m3inv_pkg::*;

    front_word_t mem [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg;
    logic [Q_AW-1:0] rp_reg;
    logic [Q_AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (Q_AW+1)'(wr_en) - (Q_AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    assign rd_data = mem[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
endmodule

### rtl/m3inv_back.sv
// Back: restoring reciprocal divider pipeline, adjugate scaling, output register.
module m3inv_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  m3inv_pkg::front_word_t in_word,
    input  logic                   stall,
    output logic                   out_valid,
    output m3inv_pkg::result_t     out_res
);
    import m3inv_pkg::*;

    localparam int NST = DIVD_WIDTH;           // one quotient bit per stage
    typedef logic [MAG_WIDTH:0]    rem_t;
    typedef logic [DIVD_WIDTH-1:0] quo_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;

    logic        v_reg   [NST+1];
    front_word_t w_reg   [NST+1];
    rem_t        r_reg   [NST+1];
    quo_t        q_reg   [NST+1];
    rem_t        dv_reg  [NST+1];
    rem_t        r_next  [NST];
    quo_t        q_next  [NST];

    // recip stage and product stage
    logic        vr_reg;
    front_word_t wr_reg;
    elem_t       rc_reg;
    elem_t       rc_next;
    logic        vp_reg;
    front_word_t wp_reg;
    prod_t       pr_reg [9];
    prod_t       pr_next [9];
    result_t     res_next;
    logic [MAG_WIDTH:0] dmag_in;
    logic [DIVD_WIDTH-1:0] qv;

    localparam quo_t DIVIDEND = quo_t'(1) << (2 * FRAC_BITS);

    always_comb
    begin
        dmag_in = in_word.det[ELEM_WIDTH-1]
                ? (MAG_WIDTH+1)'(-(MAG_WIDTH+1)'(signed'(in_word.det)))
                : (MAG_WIDTH+1)'(in_word.det);
        for (int s = 0; s < NST; s++)
        begin
            logic [MAG_WIDTH+1:0] t;
            t = {r_reg[s], DIVIDEND[NST-1-s]};
            if (t >= {1'b0, dv_reg[s]})
            begin
                r_next[s] = rem_t'(t - {1'b0, dv_reg[s]});
                q_next[s] = {q_reg[s][DIVD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next[s] = rem_t'(t);
                q_next[s] = {q_reg[s][DIVD_WIDTH-2:0], 1'b0};
            end
        end
        qv = q_reg[NST];
        if (w_reg[NST].det[ELEM_WIDTH-1])
            rc_next = (qv > DIVD_WIDTH'(ELEM_MAX) + 1'b1) ? ELEM_MIN
                                                           : elem_t'(-qv);
        else
            rc_next = (qv > DIVD_WIDTH'(ELEM_MAX)) ? ELEM_MAX : elem_t'(qv);
        for (int i = 0; i < 9; i++)
            pr_next[i] = prod_t'(wr_reg.adj[i]) * prod_t'(rc_reg);
        for (int i = 0; i < 9; i++)
            res_next.inv[i] = wp_reg.sing ? '0
                            : scale_sat((PROD_WIDTH+2)'(pr_reg[i]));
        res_next.det  = wp_reg.det;
        res_next.sing = wp_reg.sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NST; s++)
                v_reg[s] <= 1'b0;
            vr_reg    <= 1'b0;
            vp_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (!stall)
        begin
            v_reg[0] <= in_valid;
            for (int s = 0; s < NST; s++)
                v_reg[s+1] <= v_reg[s];
            vr_reg    <= v_reg[NST];
            vp_reg    <= vr_reg;
            out_valid <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            w_reg[0]  <= in_word;
            r_reg[0]  <= '0;
            q_reg[0]  <= '0;
            dv_reg[0] <= (dmag_in == '0) ? rem_t'(1) : dmag_in;
            for (int s = 0; s < NST; s++)
            begin
                w_reg[s+1]  <= w_reg[s];
                r_reg[s+1]  <= r_next[s];
                q_reg[s+1]  <= q_next[s];
                dv_reg[s+1] <= dv_reg[s];
            end
            wr_reg  <= w_reg[NST];
            rc_reg  <= rc_next;
            wp_reg  <= wr_reg;
            pr_reg  <= pr_next;
            out_res <= res_next;
        end
    end
endmodule

### rtl/matrix3_inverse.sv
// Top level: 3x3 fixed-point matrix inverse with determinant and singular flag.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+----------------------
//  input   | a00..a22                         | in_valid / in_ready
//  output  | inv00..inv22, determinant, sing. | out_valid / out_ready
//  config  | singular_threshold               | cfg_we / cfg_wdata
//
// One matrix per cycle while out_ready is high; path: 3 front stages,
// 33-stage quotient pipeline, reciprocal, product and output registers.
// The back pipeline freezes while a result waits; the front keeps going
// until the queue is full, then freezes with its words in place.
// Reset clears valid flags and threshold; payload registers are not reset.
module matrix3_inverse (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12,
    output logic signed [31:0] inv20, inv21, inv22,
    output logic signed [31:0] determinant,
    output logic singular,
    input  logic cfg_we,
    input  logic [30:0] cfg_wdata
);
    import m3inv_pkg::*;

    thr_t        thr_reg;
    mat_t        in_mat;
    logic        f_valid;
    front_word_t f_word;
    front_word_t q_word;
    logic        q_empty;
    logic [Q_AW:0] q_count;
    logic        f_stall;
    logic        b_stall;
    logic        b_take;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    assign in_mat = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

    // front may advance while the queue has a free slot
    assign f_stall  = (q_count > (Q_AW+1)'(Q_DEPTH - 1));
    assign in_ready = !f_stall;
    assign b_stall  = out_valid && !out_ready;
    assign b_take   = !b_stall && !q_empty;

    m3inv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && in_ready),
        .in_mat    (in_mat),
        .thr       (thr_reg),
        .stall     (f_stall),
        .out_valid (f_valid),
        .out_word  (f_word)
    );

    m3inv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid && !f_stall),
        .wr_data (f_word),
        .rd_en   (b_take),
        .rd_data (q_word),
        .empty   (q_empty),
        .count   (q_count)
    );

    m3inv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_take),
        .in_word   (q_word),
        .stall     (b_stall),
        .out_valid (out_valid),
        .out_res   (res)
    );

    assign inv00       = res.inv[0];
    assign inv01       = res.inv[1];
    assign inv02       = res.inv[2];
    assign inv10       = res.inv[3];
    assign inv11       = res.inv[4];
    assign inv12       = res.inv[5];
    assign inv20       = res.inv[6];
    assign inv21       = res.inv[7];
    assign inv22       = res.inv[8];
    assign determinant = res.det;
    assign singular    = res.sing;
endmodule
